/* sv/sdaf_pkg.sv */
// Package for the signed decimal ASCII formatter.
// Holds character codes, the controller state type, the converter control
// struct and the digit count function. No dependencies.
package sdaf_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 6;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } sdaf_state_t;

  typedef struct packed {
    logic load;
    logic pop;
  } sdaf_ctl_t;

  // decimal digits of 2^(w-1), the largest magnitude
  function automatic int num_digits(input int w);
    longint v;
    int     n;
    v = longint'(1) << (w - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 0) begin
        v = v / 10;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

/* sv/sdaf_bcd_conv.sv */
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// After conversion pops digits most significant first.
// Depends on sdaf_pkg.
module sdaf_bcd_conv #(
  parameter int VALUE_WIDTH = sdaf_pkg::VALUE_WIDTH_DEF,
  parameter int NUM_DIGITS  = sdaf_pkg::num_digits(sdaf_pkg::VALUE_WIDTH_DEF)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sdaf_pkg::sdaf_ctl_t              ctl,
  input  logic [VALUE_WIDTH-1:0]           mag,
  output logic                             busy,
  output logic [sdaf_pkg::DIGIT_W-1:0]     top_digit
);
  import sdaf_pkg::*;

  localparam int BCD_W = NUM_DIGITS * DIGIT_W;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.load) begin
      mag_nxt  = mag;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt  = {bcd_adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt  = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end else if (ctl.pop) begin
      bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign busy      = busy_r;
  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

endmodule

/* sv/signed_decimal_ascii_formatter.sv */
// Signed decimal ASCII formatter: one signed value in, its decimal text out.
// The sign, if negative, comes out first; leading zero digits are skipped, but the last digit is always sent.
// A new value is taken only in idle, after the last character of the previous one is issued,
// so the bit-serial BCD converter and digit emitter set the throughput.
// Reset (rst_n low, synchronous) returns to idle and drops any pending output.
// Depends on sdaf_pkg and sdaf_bcd_conv.
module signed_decimal_ascii_formatter #(
  parameter int VALUE_WIDTH = sdaf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [5:0] ascii_char
  output logic                                out_tlast
);
  import sdaf_pkg::*;

  localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  sdaf_state_t            state_r, state_nxt;
  sdaf_ctl_t              ctl;
  logic                   busy;
  logic [DIGIT_W-1:0]     top_digit;
  logic [VALUE_WIDTH-1:0] value, mag;
  logic                   neg_r, neg_nxt;
  logic                   sign_pend_r, sign_pend_nxt;
  logic                   started_r, started_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   in_acc, can_load, is_last, skip;

  assign value    = in_tdata[VALUE_WIDTH-1:0];
  assign mag      = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
  assign in_acc   = in_tvalid && in_tready;
  assign can_load = !out_valid_r || out_tready;
  assign is_last  = (rem_r == REM_W'(1));
  assign skip     = (top_digit == '0) && !started_r && !is_last;

  sdaf_bcd_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .mag       (mag),
    .busy      (busy),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_CONV;
      ST_CONV: if (!busy) state_nxt = ST_EMIT;
      ST_EMIT: if (!sign_pend_r && !skip && can_load && is_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    ctl           = '0;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    started_nxt   = started_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ctl.load  = in_tvalid;
        neg_nxt   = value[VALUE_WIDTH-1];
      end
      ST_CONV: begin
        sign_pend_nxt = neg_r;
        started_nxt   = 1'b0;
        rem_nxt       = REM_W'(NUM_DIGITS);
      end
      ST_EMIT: begin
        if (sign_pend_r) begin
          if (can_load) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CH_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end
        end else if (skip) begin
          ctl.pop = 1'b1;
          rem_nxt = rem_r - REM_W'(1);
        end else if (can_load) begin
          ctl.pop       = 1'b1;
          rem_nxt       = rem_r - REM_W'(1);
          started_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO + CHAR_W'(top_digit);
          out_last_nxt  = is_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
      started_r   <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
      started_r   <= started_nxt;
      rem_r       <= rem_nxt;
    end
    neg_r      <= in_acc ? neg_nxt : neg_r;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

/* sv/sdaf_checker.sv */
// Port-level checker for the signed decimal ASCII formatter, with its bind.
// Depends on signed_decimal_ascii_formatter.
module sdaf_checker #(
  parameter int VALUE_WIDTH = sdaf_pkg::VALUE_WIDTH_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [((VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [7:0]                       out_tdata,
  input logic                             out_tlast
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input transaction changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata == 8'd45 || (out_tdata >= 8'd48 && out_tdata <= 8'd57))
    else $error("character outside sign and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == 8'd45 |-> !out_tlast)
    else $error("minus sign marked last");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken during conversion");

endmodule

bind signed_decimal_ascii_formatter sdaf_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_sdaf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
